[rtl/tempo_map_beat_time_converter_macros.svh]
// Assertion macros shared by the tempo map converter RTL.
`ifndef TEMPO_MAP_BEAT_TIME_CONVERTER_MACROS_SVH
`define TEMPO_MAP_BEAT_TIME_CONVERTER_MACROS_SVH

// Condition must hold at every edge out of reset.
`define TMBT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TMBT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tmbt_pkg.sv]
// Types and constants shared by the tempo map converter modules.
package tmbt_pkg;

    // Input item
    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] position;
        logic [31:0] tempo_value;
    } t_in;

    // Result item
    typedef struct packed {
        logic [47:0] converted;
        logic [1:0]  status;
    } t_out;

    // One breakpoint as stored in the map memory
    typedef struct packed {
        logic [47:0] beat;
        logic [31:0] tempo;
        logic [47:0] rtime;
    } t_entry;

    // Request to the serial arithmetic unit
    typedef struct packed {
        logic       go;
        logic [1:0] op;
    } t_arith_ctl;

    // Item functions
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_B2S    = 2'd2;
    localparam logic [1:0] FN_S2B    = 2'd3;

    // Result status
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_ZERO = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    // Arithmetic unit operations
    localparam logic [1:0] OP_MULDIV = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_SQRT   = 2'd2;

    // Fixed-point constants
    localparam logic [31:0] BASIS_RESET = 32'd3932160;
    localparam logic [63:0] K_ONE16     = 64'h0000_0000_0001_0000;
    localparam logic [63:0] K_TWO17     = 64'h0000_0000_0002_0000;

endpackage

[rtl/tmbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tmbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tmbt_arith.sv]
// Bit-serial multiply/divide and digit-serial square root unit.
module tmbt_arith import tmbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_arith_ctl  i_ctl,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_c,
    output logic        o_done,
    output logic [63:0] o_res
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_CHK  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_SQRT = 3'd4;

    localparam logic [5:0] LAST64 = 6'd63;
    localparam logic [5:0] LAST32 = 6'd31;

    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;
    logic [1:0]  r_op, n_op;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_c, n_c;
    logic [63:0] r_hi, n_hi;
    logic [63:0] r_lo, n_lo;
    logic        r_done, n_done;

    logic [64:0] w_sum;
    logic [64:0] w_rem;
    logic [64:0] w_rdiff;
    logic        w_ge;
    logic [35:0] w_sq_sh;
    logic [35:0] w_sq_trial;
    logic [35:0] w_sq_diff;
    logic        w_sq_ge;

    // One step of each datapath
    always_comb begin
        w_sum      = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : 65'd0);
        w_rem      = {r_hi, r_lo[63]};
        w_ge       = w_rem >= {1'b0, r_c};
        w_rdiff    = w_rem - {1'b0, r_c};
        w_sq_sh    = {r_hi[33:0], r_lo[63:62]};
        w_sq_trial = {2'b00, r_b[31:0], 2'b01};
        w_sq_ge    = w_sq_sh >= w_sq_trial;
        w_sq_diff  = w_sq_sh - w_sq_trial;
    end

    // Sequencer
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_done  = 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_ctl.go) begin
                    n_op = i_ctl.op;
                    n_hi = '0;
                    if (i_ctl.op == OP_SQRT) begin
                        n_lo    = i_a;
                        n_b     = '0;
                        n_cnt   = LAST32;
                        n_phase = P_SQRT;
                    end else begin
                        n_a     = i_a;
                        n_b     = i_b;
                        n_c     = i_c;
                        n_lo    = '0;
                        n_cnt   = LAST64;
                        n_phase = P_MUL;
                    end
                end
            end
            // shift-add multiply, LSB of b first
            P_MUL: begin
                n_hi  = w_sum[64:1];
                n_lo  = {w_sum[0], r_lo[63:1]};
                n_b   = {1'b0, r_b[63:1]};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    if (r_op == OP_MUL) begin
                        n_done  = 1'b1;
                        n_phase = P_IDLE;
                    end else begin
                        n_phase = P_CHK;
                    end
                end
            end
            // quotient overflow saturates
            P_CHK: begin
                if (r_c == 64'd0 || r_hi >= r_c) begin
                    n_lo    = '1;
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_cnt   = LAST64;
                    n_phase = P_DIV;
                end
            end
            // restoring division, quotient shifts into lo
            P_DIV: begin
                n_hi  = w_ge ? w_rdiff[63:0] : w_rem[63:0];
                n_lo  = {r_lo[62:0], w_ge};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            // two radicand bits per step
            P_SQRT: begin
                n_hi  = {28'd0, w_sq_ge ? w_sq_diff : w_sq_sh};
                n_b   = {r_b[62:0], w_sq_ge};
                n_lo  = {r_lo[61:0], 2'b00};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_SQRT) ? r_b : r_lo;

endmodule

[rtl/tempo_map_beat_time_converter.sv]
// Tempo map: breakpoint store and beat/second conversion sequencer.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_data
//   out     | output    | o_out_valid / i_out_ready | o_out_data
//   cfg     | input     | i_cfg_we (no wait)        | i_cfg_data
//
// One item at a time. Clear and pass-through skip the arithmetic unit; append,
// seconds to beats and beats to seconds wait on it, so the bit-serial
// multiply/divide unit sets how long they take.
// The breakpoint search reads the map memory one entry per cycle.
// Reset is synchronous; the map starts empty. A stalled result sits in the
// output register while the next item is taken.
`include "tempo_map_beat_time_converter_macros.svh"
module tempo_map_beat_time_converter import tmbt_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int DEPTH = MAX_POINTS + 1;
    localparam int CW    = $clog2(DEPTH);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AP_V   = 5'd1;
    localparam logic [4:0] S_AP_RD  = 5'd2;
    localparam logic [4:0] S_AP_LEN = 5'd3;
    localparam logic [4:0] S_AP_RT  = 5'd4;
    localparam logic [4:0] S_AP_WR  = 5'd5;
    localparam logic [4:0] S_SR_CMP = 5'd6;
    localparam logic [4:0] S_LD0    = 5'd7;
    localparam logic [4:0] S_LD1    = 5'd8;
    localparam logic [4:0] S_SEG    = 5'd9;
    localparam logic [4:0] S_SQ0    = 5'd10;
    localparam logic [4:0] S_SQ1    = 5'd11;
    localparam logic [4:0] S_VQ     = 5'd12;
    localparam logic [4:0] S_RT     = 5'd13;
    localparam logic [4:0] S_VS     = 5'd14;
    localparam logic [4:0] S_FINAL  = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    // saturating 48-bit add of a 64-bit offset
    function automatic logic [47:0] f_add48(input logic [47:0] a, input logic [63:0] b);
        logic [47:0] bs;
        logic [48:0] s;
        bs = (b[63:48] != 16'd0) ? '1 : b[47:0];
        s  = {1'b0, a} + {1'b0, bs};
        return s[48] ? '1 : s[47:0];
    endfunction

    logic [4:0]    r_state, n_state;
    logic [31:0]   r_basis, n_basis;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_m, n_m;
    logic [1:0]    r_func, n_func;
    logic [47:0]   r_pos, n_pos;
    logic [31:0]   r_v, n_v;
    logic [47:0]   r_beat0, n_beat0;
    logic [31:0]   r_tmp0, n_tmp0;
    logic [47:0]   r_rt0, n_rt0;
    logic [47:0]   r_beat1, n_beat1;
    logic [31:0]   r_tmp1, n_tmp1;
    logic [47:0]   r_rt1, n_rt1;
    logic [63:0]   r_s0, n_s0;
    logic [63:0]   r_s1, n_s1;
    t_out          r_res, n_res;
    t_out          r_out, n_out;
    logic          r_ovalid, n_ovalid;
    logic          r_go, n_go;
    logic [1:0]    r_op, n_op;
    logic [63:0]   r_opa, n_opa;
    logic [63:0]   r_opb, n_opb;
    logic [63:0]   r_opc, n_opc;

    logic          w_we;
    logic [CW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [CW-1:0] w_raddr;
    t_entry        w_rd;
    logic [127:0]  w_rd_bits;

    t_arith_ctl    w_actl;
    logic          w_adone;
    logic [63:0]   w_ares;

    logic          w_b2s;
    logic [47:0]   w_mark0, w_mark1, w_base, w_off, w_len, w_rd_mark;
    logic [31:0]   w_vsat, w_vdiff;
    logic          w_vup;
    logic [32:0]   w_v0x2;
    logic          w_last;
    logic          w_wait_st;

    // Map memory: one breakpoint per entry
    tmbt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_bits)
    );
    assign w_rd = t_entry'(w_rd_bits);

    // Shared serial arithmetic
    assign w_actl.go = r_go;
    assign w_actl.op = r_op;

    tmbt_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_actl),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .i_c     (r_opc),
        .o_done  (w_adone),
        .o_res   (w_ares)
    );

    // Segment quantities in the search domain of the current item
    always_comb begin
        w_b2s     = (r_func == FN_B2S);
        w_mark0   = w_b2s ? r_beat0 : r_rt0;
        w_mark1   = w_b2s ? r_beat1 : r_rt1;
        w_base    = w_b2s ? r_rt0 : r_beat0;
        w_off     = r_pos - w_mark0;
        w_len     = w_mark1 - w_mark0;
        w_rd_mark = w_b2s ? w_rd.beat : w_rd.rtime;
        w_vsat    = (w_ares[63:32] != 32'd0) ? '1 : w_ares[31:0];
        w_vup     = r_tmp1 >= r_tmp0;
        w_vdiff   = w_vup ? r_tmp1 - r_tmp0 : r_tmp0 - r_tmp1;
        w_v0x2    = {1'b0, r_tmp0} + {1'b0, r_tmp0};
        w_last    = (r_m == r_count);
    end

    // States that wait on the arithmetic unit
    assign w_wait_st = (r_state == S_AP_V) || (r_state == S_AP_RT) ||
                       (r_state == S_SQ0)  || (r_state == S_SQ1)   ||
                       (r_state == S_VQ)   || (r_state == S_RT)    ||
                       (r_state == S_VS)   || (r_state == S_FINAL);

    // Main sequencer
    always_comb begin
        logic        lt;
        logic [CW-1:0] m_new;
        logic [63:0] vsq;
        logic [31:0] vs;

        n_state  = r_state;
        n_basis  = i_cfg_we ? i_cfg_data : r_basis;
        n_count  = r_count;
        n_idx    = r_idx;
        n_m      = r_m;
        n_func   = r_func;
        n_pos    = r_pos;
        n_v      = r_v;
        n_beat0  = r_beat0;
        n_tmp0   = r_tmp0;
        n_rt0    = r_rt0;
        n_beat1  = r_beat1;
        n_tmp1   = r_tmp1;
        n_rt1    = r_rt1;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = (r_ovalid && i_out_ready) ? 1'b0 : r_ovalid;
        n_go     = 1'b0;
        n_op     = r_op;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_opc    = r_opc;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = '0;
        lt       = w_rd_mark < r_pos;
        m_new    = lt ? r_idx : r_m;
        vsq      = (r_s1 >= r_s0) ? r_s0 + w_ares : r_s0 - w_ares;
        vs       = w_vup ? r_tmp0 + w_ares[31:0] : r_tmp0 - w_ares[31:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_data.func;
                    n_pos  = i_in_data.position;
                    n_res  = '0;
                    case (i_in_data.func)
                        FN_CLEAR: begin
                            n_count = '0;
                            n_state = S_OUT;
                        end
                        FN_APPEND: begin
                            // tempo in beats per second
                            n_go    = 1'b1;
                            n_op    = OP_MULDIV;
                            n_opa   = {32'd0, i_in_data.tempo_value};
                            n_opb   = K_ONE16;
                            n_opc   = (r_basis == 32'd0) ? 64'd1 : {32'd0, r_basis};
                            n_state = S_AP_V;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res.converted = i_in_data.position;
                                n_state         = S_OUT;
                            end else begin
                                n_idx   = CW'(1);
                                n_m     = '0;
                                w_raddr = CW'(1);
                                n_state = S_SR_CMP;
                            end
                        end
                    endcase
                end
            end
            // append: check tempo and room, fetch previous point
            S_AP_V: begin
                if (w_adone) begin
                    if (w_vsat == 32'd0) begin
                        n_res.status = STS_ZERO;
                        n_state      = S_OUT;
                    end else if (r_count >= CW'(MAX_POINTS)) begin
                        n_res.status = STS_FULL;
                        n_state      = S_OUT;
                    end else begin
                        n_v = w_vsat;
                        if (r_count == '0) begin
                            n_beat0       = '0;
                            n_tmp0        = w_vsat;
                            n_rt0         = '0;
                            w_we          = 1'b1;
                            w_waddr       = '0;
                            w_wdata.beat  = '0;
                            w_wdata.tempo = w_vsat;
                            w_wdata.rtime = '0;
                            n_state       = S_AP_LEN;
                        end else begin
                            w_raddr = r_count;
                            n_state = S_AP_RD;
                        end
                    end
                end
            end
            S_AP_RD: begin
                n_beat0 = w_rd.beat;
                n_tmp0  = w_rd.tempo;
                n_rt0   = w_rd.rtime;
                n_state = S_AP_LEN;
            end
            // backwards beat clamps to the previous one
            S_AP_LEN: begin
                if (r_pos <= r_beat0) begin
                    n_pos   = r_beat0;
                    n_rt1   = r_rt0;
                    n_state = S_AP_WR;
                end else begin
                    n_go    = 1'b1;
                    n_op    = OP_MULDIV;
                    n_opa   = {16'd0, r_pos - r_beat0};
                    n_opb   = K_TWO17;
                    n_opc   = {31'd0, {1'b0, r_tmp0} + {1'b0, r_v}};
                    n_state = S_AP_RT;
                end
            end
            S_AP_RT: begin
                if (w_adone) begin
                    n_rt1   = f_add48(r_rt0, w_ares);
                    n_state = S_AP_WR;
                end
            end
            S_AP_WR: begin
                w_we          = 1'b1;
                w_waddr       = r_count + CW'(1);
                w_wdata.beat  = r_pos;
                w_wdata.tempo = r_v;
                w_wdata.rtime = r_rt1;
                n_count       = r_count + CW'(1);
                n_state       = S_OUT;
            end
            // linear search, one entry per cycle; marks never decrease
            S_SR_CMP: begin
                n_m = m_new;
                if (!lt || r_idx == r_count) begin
                    w_raddr = m_new;
                    n_state = S_LD0;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    w_raddr = r_idx + CW'(1);
                end
            end
            S_LD0: begin
                n_beat0 = w_rd.beat;
                n_tmp0  = w_rd.tempo;
                n_rt0   = w_rd.rtime;
                if (!w_last) begin
                    w_raddr = r_m + CW'(1);
                end
                n_state = S_LD1;
            end
            S_LD1: begin
                if (!w_last) begin
                    n_beat1 = w_rd.beat;
                    n_tmp1  = w_rd.tempo;
                    n_rt1   = w_rd.rtime;
                end
                n_state = S_SEG;
            end
            // pick the segment formula
            S_SEG: begin
                n_go  = 1'b1;
                n_op  = OP_MULDIV;
                n_opa = {16'd0, w_off};
                if (w_last) begin
                    n_opb   = w_b2s ? K_ONE16 : {32'd0, r_tmp0};
                    n_opc   = w_b2s ? {32'd0, r_tmp0} : K_ONE16;
                    n_state = S_FINAL;
                end else if (w_len == 48'd0) begin
                    n_opb   = w_b2s ? K_TWO17 : {31'd0, w_v0x2};
                    n_opc   = w_b2s ? {31'd0, w_v0x2} : K_TWO17;
                    n_state = S_FINAL;
                end else if (w_b2s) begin
                    n_op    = OP_MUL;
                    n_opa   = {32'd0, r_tmp0};
                    n_opb   = {32'd0, r_tmp0};
                    n_state = S_SQ0;
                end else begin
                    n_opa   = {32'd0, w_vdiff};
                    n_opb   = {16'd0, w_off};
                    n_opc   = {16'd0, w_len};
                    n_state = S_VS;
                end
            end
            S_SQ0: begin
                if (w_adone) begin
                    n_s0    = w_ares;
                    n_go    = 1'b1;
                    n_op    = OP_MUL;
                    n_opa   = {32'd0, r_tmp1};
                    n_opb   = {32'd0, r_tmp1};
                    n_state = S_SQ1;
                end
            end
            S_SQ1: begin
                if (w_adone) begin
                    n_s1    = w_ares;
                    n_go    = 1'b1;
                    n_op    = OP_MULDIV;
                    n_opa   = (w_ares >= r_s0) ? w_ares - r_s0 : r_s0 - w_ares;
                    n_opb   = {16'd0, w_off};
                    n_opc   = {16'd0, w_len};
                    n_state = S_VQ;
                end
            end
            S_VQ: begin
                if (w_adone) begin
                    n_go    = 1'b1;
                    n_op    = OP_SQRT;
                    n_opa   = vsq;
                    n_state = S_RT;
                end
            end
            S_RT: begin
                if (w_adone) begin
                    n_go    = 1'b1;
                    n_op    = OP_MULDIV;
                    n_opa   = {16'd0, w_off};
                    n_opb   = K_TWO17;
                    n_opc   = {31'd0, {1'b0, r_tmp0} + {1'b0, w_ares[31:0]}};
                    n_state = S_FINAL;
                end
            end
            S_VS: begin
                if (w_adone) begin
                    n_go    = 1'b1;
                    n_op    = OP_MULDIV;
                    n_opa   = {16'd0, w_off};
                    n_opb   = {31'd0, {1'b0, r_tmp0} + {1'b0, vs}};
                    n_opc   = K_TWO17;
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (w_adone) begin
                    n_res.converted = f_add48(w_base, w_ares);
                    n_res.status    = STS_OK;
                    n_state         = S_OUT;
                end
            end
            // hand the result to the output register
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_basis  <= BASIS_RESET;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_go     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_basis  <= n_basis;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_go     <= n_go;
        end
        r_idx   <= n_idx;
        r_m     <= n_m;
        r_func  <= n_func;
        r_pos   <= n_pos;
        r_v     <= n_v;
        r_beat0 <= n_beat0;
        r_tmp0  <= n_tmp0;
        r_rt0   <= n_rt0;
        r_beat1 <= n_beat1;
        r_tmp1  <= n_tmp1;
        r_rt1   <= n_rt1;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_res   <= n_res;
        r_out   <= n_out;
        r_op    <= n_op;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_opc   <= n_opc;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Checks
    `TMBT_ASSERT_ALWAYS(a_count_range, r_count <= CW'(MAX_POINTS), "point count beyond capacity")
    `TMBT_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state != S_IDLE, "item not started")
    `TMBT_ASSERT_IMPLIES(a_done_waited, w_adone, w_wait_st, "arith result with no waiting state")

endmodule
